FILE: rtl/core/smpq_pkg.sv
package smpq_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int DATA_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int OCC_W     = 5;

   // operation codes
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic                     kind;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] removed_value;
      logic [STATUS_W-1:0]      status;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

endpackage

FILE: rtl/core/smpq_ram.sv
module smpq_ram #(
   parameter int DEPTH = smpq_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [smpq_pkg::DATA_W-1:0]       wr_data,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [smpq_pkg::DATA_W-1:0]       rd_data
);
   import smpq_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sorted_min_priority_queue.sv
// A remove returns the head entry via ST_REM; a failed insert or remove, or an
//   insert into an empty queue, goes straight to ST_DONE; other inserts shift
//   in ST_SCAN (then ST_HEAD for a new minimum) before ST_DONE. One transaction
//   at a time; the insert scan moves one entry per cycle, from the tail down.
// Reset: synchronous, active high; the queue comes up empty, the entry
//   memory itself is not cleared (entries are only read below the count).
module sorted_min_priority_queue #(
   parameter int DEPTH = smpq_pkg::DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  smpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output smpq_pkg::rsp_type rsp_data
);
   import smpq_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // control states
   localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a transaction
   localparam logic [2:0] ST_SCAN = 3'd1;  // insert: shifting larger entries up
   localparam logic [2:0] ST_HEAD = 3'd2;  // insert: new value becomes the minimum
   localparam logic [2:0] ST_REM  = 3'd3;  // remove: read data returns
   localparam logic [2:0] ST_DONE = 3'd4;  // result waits for the output register

   logic [2:0]              state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [AW-1:0]           head_ff, head_in;      // physical slot of logical entry 0
   logic [AW-1:0]           scan_log_ff, scan_log_in;   // logical index of returning data
   logic [AW-1:0]           scan_phys_ff, scan_phys_in; // its physical slot
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] res_value_ff, res_value_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [DATA_W-1:0]       wr_data;
   logic [AW-1:0]           rd_addr;
   logic [DATA_W-1:0]       rd_data;

   logic                    accept;
   logic                    out_free;
   logic [SUM_W-1:0]        tail_sum;
   logic [AW-1:0]           tail_phys;   // physical slot of the last stored entry
   logic [AW-1:0]           scan_up;
   logic [AW-1:0]           scan_down;
   logic [AW-1:0]           head_up;
   logic                    shift_entry; // returning entry is larger than new value

   smpq_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // circular addressing; one compare-subtract per wrap
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff) - SUM_W'(1);
      if (tail_sum >= SUM_W'(DEPTH)) begin
         tail_phys = AW'(tail_sum - SUM_W'(DEPTH));
      end else begin
         tail_phys = AW'(tail_sum);
      end
      scan_up   = (scan_phys_ff == AW'(DEPTH - 1)) ? '0 : scan_phys_ff + AW'(1);
      scan_down = (scan_phys_ff == '0) ? AW'(DEPTH - 1) : scan_phys_ff - AW'(1);
      head_up   = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   end

   assign shift_entry = ($signed(rd_data) > val_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      scan_log_in   = scan_log_ff;
      scan_phys_in  = scan_phys_ff;
      val_in        = val_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      wr_data       = val_ff;
      rd_addr       = head_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_data.kind == KIND_INSERT) begin
               rd_addr = tail_phys;
            end
            if (accept) begin
               val_in        = req_data.value;
               res_value_in  = '0;
               res_status_in = STAT_OK;
               if (req_data.kind == KIND_INSERT) begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     res_status_in = STAT_FULL;
                     state_in      = ST_DONE;
                  end else if (count_ff == '0) begin
                     // empty queue: new value goes straight to the head slot
                     wr_en    = 1'b1;
                     wr_addr  = head_ff;
                     wr_data  = req_data.value;
                     count_in = count_ff + CNT_W'(1);
                     state_in = ST_DONE;
                  end else begin
                     // read of the tail entry issued now, scan starts next cycle
                     scan_log_in  = AW'(count_ff - CNT_W'(1));
                     scan_phys_in = tail_phys;
                     count_in     = count_ff + CNT_W'(1);
                     state_in     = ST_SCAN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                     state_in      = ST_DONE;
                  end else begin
                     head_in  = head_up;
                     count_in = count_ff - CNT_W'(1);
                     state_in = ST_REM;
                  end
               end
            end
         end

         ST_SCAN: begin
            // next-lower entry is read ahead every cycle; a surplus read is dropped
            rd_addr = scan_down;
            wr_en   = 1'b1;
            wr_addr = scan_up;
            if (shift_entry) begin
               wr_data = rd_data;
               if (scan_log_ff == '0) begin
                  state_in = ST_HEAD;
               end else begin
                  scan_log_in  = scan_log_ff - AW'(1);
                  scan_phys_in = scan_down;
               end
            end else begin
               wr_data  = val_ff;
               state_in = ST_DONE;
            end
         end

         ST_HEAD: begin
            wr_en    = 1'b1;
            wr_addr  = head_ff;
            wr_data  = val_ff;
            state_in = ST_DONE;
         end

         ST_REM: begin
            res_value_in = $signed(rd_data);
            state_in     = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.removed_value   = res_value_ff;
               rsp_data_in.status          = res_status_ff;
               rsp_data_in.occupancy       = OCC_W'(count_ff);
               state_in                    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_log_ff   <= scan_log_in;
      scan_phys_ff  <= scan_phys_in;
      val_ff        <= val_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // stored count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   // every accepted transaction leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("transaction accepted without starting work");

   // a new result is only loaded from the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared outside done state");

   // failed operations return zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != STAT_OK)) |->
         (rsp_data_ff.removed_value == '0))
      else $error("failed transaction returned nonzero value");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import smpq_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEF;
   // Longest path: an insert below DEPTH - 1 larger entries, plus stalls.
   localparam int DRAIN_CYCLES = QUEUE_DEPTH + 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Percentage of cycles each side holds back.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int fail_count  = 0;
   int cycle_count = 0;

   // Shadow of the queue contents, kept in ascending order.
   logic signed [DATA_W-1:0] model_values[$];
   // Predicted responses, oldest first.
   rsp_type op_outcomes[$];
   rsp_type want;

   sorted_min_priority_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses still outstanding", $time,
                  op_outcomes.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Applies one accepted transaction to the shadow queue and returns the
   // response the block must give. A new value lands after any equal ones.
   function automatic rsp_type apply_queue_op(req_type item);
      rsp_type r;
      int      pos;
      r        = '0;
      r.status = STAT_OK;
      if (item.kind == KIND_INSERT) begin
         if (model_values.size() >= QUEUE_DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            pos = 0;
            while (pos < model_values.size() && model_values[pos] <= item.value)
               pos++;
            model_values.insert(pos, item.value);
         end
      end else begin
         if (model_values.size() == 0)
            r.status = STAT_EMPTY;
         else
            r.removed_value = model_values.pop_front();
      end
      r.occupancy = OCC_W'(model_values.size());
      return r;
   endfunction

   // Values weighted toward the extremes and a narrow band around zero, so
   // duplicates are common.
   function automatic logic signed [DATA_W-1:0] pick_value();
      int sel;
      int near;
      sel  = $urandom_range(0, 9);
      near = $urandom_range(0, 8);
      case (sel)
         0: return VAL_MIN;
         1: return VAL_MAX;
         2, 3: return near - 4;
         default: return $urandom();
      endcase
   endfunction

   // Called just after the clock rises. Holds valid and payload until the
   // transaction is taken, then records the prediction.
   task automatic send_item(input logic kind, input logic signed [DATA_W-1:0] value);
      req_type item;
      item.kind  = kind;
      item.value = value;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      op_outcomes.push_back(apply_queue_op(item));
   endtask

   // Response side: random backpressure and in-order comparison.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (op_outcomes.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d",
                     $time, rsp_data.removed_value, rsp_data.status,
                     rsp_data.occupancy);
            fail_count++;
         end else begin
            want = op_outcomes.pop_front();
            if (rsp_data.removed_value !== want.removed_value) begin
               $display("%0t: removed_value mismatch, expected %0d, actual %0d",
                        $time, want.removed_value, rsp_data.removed_value);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.occupancy !== want.occupancy) begin
               $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                        $time, want.occupancy, rsp_data.occupancy);
               fail_count++;
            end
         end
      end
   end

   // Remove on an empty queue must give zero and the empty status.
   task automatic test_remove_when_empty();
      send_item(KIND_REMOVE, 32'shffff_ffff);
      send_item(KIND_REMOVE, 32'sh0);
   endtask

   // Inserting a value equal to the only stored one, then draining past empty.
   task automatic test_equal_values();
      send_item(KIND_INSERT, 32'sd7);
      send_item(KIND_INSERT, 32'sd7);
      send_item(KIND_REMOVE, 32'sd0);
      send_item(KIND_REMOVE, 32'sd0);
      send_item(KIND_REMOVE, 32'sd0);
   endtask

   // Fill with extremes and mixed signs, then one insert into a full queue.
   task automatic test_fill_to_full();
      logic signed [DATA_W-1:0] fill_values[QUEUE_DEPTH];
      fill_values = '{VAL_MIN, VAL_MAX, 32'sd0, -32'sd1, 32'sd1, VAL_MAX, VAL_MIN,
                      -32'sd2, 32'sd2, 32'sd100, -32'sd100, 32'sd0, 32'sh4000_0000,
                      32'shc000_0000, 32'sd1, -32'sd1};
      foreach (fill_values[i])
         send_item(KIND_INSERT, fill_values[i]);
      send_item(KIND_INSERT, 32'sh5555_5555);
   endtask

   // Random mix in episodes that lean toward filling, draining or neither,
   // so the occupancy sweeps from empty to full and back.
   task automatic test_random_traffic(input int count);
      int   insert_pct;
      logic kind;
      insert_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 20 == 0) begin
            case ($urandom_range(0, 2))
               0: insert_pct = 85;
               1: insert_pct = 50;
               default: insert_pct = 15;
            endcase
         end
         kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
         send_item(kind, pick_value());
      end
   endtask

   initial begin
      send_idle_pct = 37;
      recv_idle_pct = 67;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_remove_when_empty();
      test_equal_values();
      test_fill_to_full();

      test_random_traffic(285);
      send_idle_pct = 67;
      recv_idle_pct = 37;
      test_random_traffic(285);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(285);

      req_valid <= 1'b0;
      while (op_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: sorted_min_priority_queue.f
rtl/core/smpq_pkg.sv
rtl/core/smpq_ram.sv
rtl/core/sorted_min_priority_queue.sv
test/testbench.sv
